@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/vca_pkg.sv @@
package vca_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [1:0] KIND_NEW   = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_EDGE,
        OP_SOLVE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] count;
        logic [4:0] vert_a;
        logic [4:0] vert_b;
    } cmd_t;

endpackage

@@ src/vertex_cover_approximator.sv @@
// Channel  | handshake            | payload
// -------- | -------------------- | -------------------------------------
// input    | in_valid / in_stall  | kind, vertex_count, vert_a, vert_b
// output   | out_valid / out_stall| algorithm, vertex, cover_empty, last
//
// New-graph and edge words pass at one word per cycle while in_stall is low,
// through a four-entry command queue.
// A solve runs a greedy pass (one row popcount per cycle over the N vertices in
// use, rescanning from the first row after each cover vertex is taken), then a
// pair pass, then emits the result words, holding each while out_stall is set.
// Reset clears the adjacency matrix, the queue and the output valid flag.
// in_stall rises only when the queue is full; out_stall holds the result.
module vertex_cover_approximator #(
    parameter int MAX_VERTICES = vca_pkg::MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [5:0] vertex_count,
    input  logic [4:0] vert_a,
    input  logic [4:0] vert_b,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       algorithm,
    output logic [4:0] vertex,
    output logic       cover_empty,
    output logic       last
);
    import vca_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_out;

    vca_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .vertex_count (vertex_count),
        .vert_a       (vert_a),
        .vert_b       (vert_b),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    vca_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    vca_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .algorithm   (algorithm),
        .vertex      (vertex),
        .cover_empty (cover_empty),
        .last        (last)
    );

endmodule

@@ src/vca_front.sv @@
module vca_front #(
    parameter int MAX_VERTICES = vca_pkg::MAX_VERTICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    kind,
    input  logic [5:0]    vertex_count,
    input  logic [4:0]    vert_a,
    input  logic [4:0]    vert_b,
    input  logic          q_full,
    output logic          q_push,
    output vca_pkg::cmd_t q_data
);
    import vca_pkg::*;

    localparam logic [5:0] MAX_N = 6'(MAX_VERTICES);

    logic [5:0] n_reg;
    logic [5:0] n_next;
    logic [5:0] count_sat;
    logic       keep;
    logic       accept;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign count_sat = (vertex_count > MAX_N) ? MAX_N : vertex_count;

    // Classify the word; drop edges that are out of range or self loops, and words of unknown kind.
    always_comb
    begin
        keep        = 1'b0;
        n_next      = n_reg;
        q_data      = '0;
        q_data.op   = OP_CLEAR;
        q_data.count  = count_sat;
        q_data.vert_a = vert_a;
        q_data.vert_b = vert_b;
        unique case (kind)
            KIND_NEW:
            begin
                keep   = 1'b1;
                n_next = count_sat;
            end
            KIND_EDGE:
            begin
                q_data.op = OP_EDGE;
                keep = ({1'b0, vert_a} < n_reg) && ({1'b0, vert_b} < n_reg)
                       && (vert_a != vert_b);
            end
            KIND_SOLVE:
            begin
                q_data.op = OP_SOLVE;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= '0;
        else if (accept)
            n_reg <= n_next;
    end

endmodule

@@ src/vca_queue.sv @@
`include "assert_macros.svh"

module vca_queue #(
    parameter int DEPTH = vca_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vca_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output vca_pkg::cmd_t pop_data,
    output logic          empty
);
    import vca_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_IMPL(no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPL(no_underflow, clk, rst_n, pop, !empty)

endmodule

@@ src/vca_back.sv @@
`include "assert_macros.svh"

module vca_back #(
    parameter int MAX_VERTICES = vca_pkg::MAX_VERTICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  vca_pkg::cmd_t q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          algorithm,
    output logic [4:0]    vertex,
    output logic          cover_empty,
    output logic          last
);
    import vca_pkg::*;

    localparam int MV = MAX_VERTICES;
    localparam int IW = $clog2(MV);
    localparam int CW = $clog2(MV + 1);
    localparam logic [MV-1:0] ONE = MV'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_GSCAN = 3'd2;
    localparam logic [2:0] S_PLOAD = 3'd3;
    localparam logic [2:0] S_PSCAN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [MV-1:0] adj_reg  [MV];
    logic [MV-1:0] adj_next [MV];
    logic [MV-1:0] work_reg [MV];
    logic [MV-1:0] work_next [MV];
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] v_reg, v_next;
    logic [IW-1:0] best_reg, best_next;
    logic [CW-1:0] bcnt_reg, bcnt_next;
    logic [MV-1:0] gcov_reg, gcov_next;
    logic [MV-1:0] pcov_reg, pcov_next;
    logic          alg_reg, alg_next;
    logic          empty_reg, empty_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_alg_reg, out_alg_next;
    logic [IW-1:0] out_vert_reg, out_vert_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_last_reg, out_last_next;

    logic [MV-1:0] live;
    logic [MV-1:0] row;
    logic [CW-1:0] cnt;
    logic          take;
    logic [IW-1:0] best_new;
    logic [CW-1:0] bcnt_new;
    logic          scan_end;
    logic [IW-1:0] row_low;
    logic [MV-1:0] eset;
    logic [IW-1:0] elow;
    logic [MV-1:0] erest;
    logic          slot_free;
    logic          load_en;
    logic          drop0_en, drop1_en;
    logic [IW-1:0] drop0, drop1;
    logic [IW-1:0] ea, eb;

    function automatic logic [IW-1:0] low_bit(input logic [MV-1:0] r);
        logic [IW-1:0] idx;
        idx = '0;
        for (int j = MV - 1; j >= 0; j--)
        begin
            if (r[j])
                idx = IW'(j);
        end
        return idx;
    endfunction

    always_comb
    begin
        for (int j = 0; j < MV; j++)
            live[j] = (CW'(j) < n_reg);
    end

    assign row      = work_reg[v_reg];
    assign cnt      = CW'($countones(row));
    assign take     = cnt > bcnt_reg;
    assign best_new = take ? v_reg : best_reg;
    assign bcnt_new = take ? cnt : bcnt_reg;
    assign scan_end = ((CW + 1)'(v_reg) + (CW + 1)'(1)) >= (CW + 1)'(n_reg);
    assign row_low  = low_bit(row);
    assign eset     = alg_reg ? pcov_reg : gcov_reg;
    assign elow     = low_bit(eset);
    assign erest    = eset & ~(ONE << elow);
    assign slot_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign ea       = IW'(q_data.vert_a);
    assign eb       = IW'(q_data.vert_b);

    always_comb
    begin
        state_next = state_reg;
        adj_next   = adj_reg;
        n_next     = n_reg;
        v_next     = v_reg;
        best_next  = best_reg;
        bcnt_next  = bcnt_reg;
        gcov_next  = gcov_reg;
        pcov_next  = pcov_reg;
        alg_next   = alg_reg;
        empty_next = empty_reg;
        load_en    = 1'b0;
        drop0_en   = 1'b0;
        drop1_en   = 1'b0;
        drop0      = best_new;
        drop1      = row_low;
        out_valid_next = out_valid_reg && out_stall;
        out_alg_next   = out_alg_reg;
        out_vert_next  = out_vert_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_data.op)
                        OP_CLEAR:
                        begin
                            for (int i = 0; i < MV; i++)
                                adj_next[i] = '0;
                            n_next = CW'(q_data.count);
                        end
                        OP_EDGE:
                        begin
                            for (int i = 0; i < MV; i++)
                            begin
                                if (IW'(i) == ea)
                                    adj_next[i][eb] = 1'b1;
                                if (IW'(i) == eb)
                                    adj_next[i][ea] = 1'b1;
                            end
                        end
                        OP_SOLVE:
                        begin
                            state_next = S_LOAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                load_en    = 1'b1;
                gcov_next  = '0;
                v_next     = '0;
                best_next  = '0;
                bcnt_next  = '0;
                state_next = S_GSCAN;
            end
            S_GSCAN:
            begin
                if (!scan_end)
                begin
                    v_next    = v_reg + IW'(1);
                    best_next = best_new;
                    bcnt_next = bcnt_new;
                end
                else if (bcnt_new == '0)
                begin
                    if (gcov_reg == '0)
                    begin
                        empty_next = 1'b1;
                        alg_next   = 1'b0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_PLOAD;
                    end
                end
                else
                begin
                    // Take the best vertex and rescan from the first row.
                    gcov_next = gcov_reg | (ONE << best_new);
                    drop0_en  = 1'b1;
                    v_next    = '0;
                    best_next = '0;
                    bcnt_next = '0;
                end
            end
            S_PLOAD:
            begin
                load_en    = 1'b1;
                pcov_next  = '0;
                v_next     = '0;
                state_next = S_PSCAN;
            end
            S_PSCAN:
            begin
                drop0 = v_reg;
                if (row != '0)
                begin
                    pcov_next = pcov_reg | (ONE << v_reg) | (ONE << row_low);
                    drop0_en  = 1'b1;
                    drop1_en  = 1'b1;
                end
                if (scan_end)
                begin
                    empty_next = 1'b0;
                    alg_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    v_next = v_reg + IW'(1);
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        out_alg_next   = 1'b0;
                        out_vert_next  = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        empty_next     = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_alg_next   = alg_reg;
                        out_vert_next  = elow;
                        out_empty_next = 1'b0;
                        out_last_next  = alg_reg && (erest == '0);
                        if (alg_reg)
                            pcov_next = erest;
                        else
                            gcov_next = erest;
                        if (erest == '0)
                        begin
                            if (alg_reg)
                                state_next = S_IDLE;
                            else
                                alg_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load or prune the scratch rows, each row at its own place.
    always_comb
    begin
        for (int i = 0; i < MV; i++)
        begin
            if (load_en)
            begin
                work_next[i] = (CW'(i) < n_reg) ? (adj_reg[i] & live) : '0;
            end
            else
            begin
                work_next[i] = work_reg[i];
                if (drop0_en)
                begin
                    if (IW'(i) == drop0)
                        work_next[i] = '0;
                    work_next[i][drop0] = 1'b0;
                end
                if (drop1_en)
                begin
                    if (IW'(i) == drop1)
                        work_next[i] = '0;
                    work_next[i][drop1] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            gcov_reg      <= '0;
            pcov_reg      <= '0;
            alg_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MV; i++)
                adj_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            gcov_reg      <= gcov_next;
            pcov_reg      <= pcov_next;
            alg_reg       <= alg_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            adj_reg       <= adj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        v_reg         <= v_next;
        best_reg      <= best_next;
        bcnt_reg      <= bcnt_next;
        out_alg_reg   <= out_alg_next;
        out_vert_reg  <= out_vert_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign algorithm   = out_alg_reg;
    assign vertex      = 5'(out_vert_reg);
    assign cover_empty = out_empty_reg;
    assign last        = out_last_reg;

    `ASSERT_IMPL(empty_is_last, clk, rst_n, out_valid_reg && out_empty_reg,
        out_last_reg && !out_alg_reg)
    `ASSERT_NEXT(greedy_rescan, clk, rst_n,
        (state_reg == S_GSCAN) && scan_end && (bcnt_new != '0),
        (state_reg == S_GSCAN) && (v_reg == '0))
    `ASSERT_NEXT(empty_leaves, clk, rst_n,
        (state_reg == S_EMIT) && empty_reg && slot_free,
        (state_reg == S_IDLE) && out_valid_reg && out_empty_reg)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import vca_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = KIND_NEW;
    logic [5:0] vertex_count = '0;
    logic [4:0] vert_a = '0;
    logic [4:0] vert_b = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       algorithm;
    logic [4:0] vertex;
    logic       cover_empty;
    logic       last;

    typedef struct packed {
        logic       alg;
        logic [4:0] vtx;
        logic       empty;
        logic       fin;
    } cover_word_t;

    cover_word_t pending_covers[$];
    logic [31:0] graph_rows[32];
    logic [31:0] scratch[32];
    int          live_count;
    int          error_count = 0;
    int          words_seen = 0;
    int          solves_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    longint      cycles = 0;

    vertex_cover_approximator u_top (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // check each word against the oldest pending one
    always @(posedge clk)
    begin
        cover_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_covers.size() == 0)
            begin
                $error("unexpected word alg=%0d vertex=%0d", algorithm, vertex);
                error_count++;
            end
            else
            begin
                want = pending_covers.pop_front();
                if (algorithm !== want.alg)
                begin
                    $error("algorithm: expected %0d, got %0d", want.alg, algorithm);
                    error_count++;
                end
                if (vertex !== want.vtx)
                begin
                    $error("vertex: expected %0d, got %0d", want.vtx, vertex);
                    error_count++;
                end
                if (cover_empty !== want.empty)
                begin
                    $error("cover_empty: expected %0d, got %0d", want.empty, cover_empty);
                    error_count++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0d, got %0d", want.fin, last);
                    error_count++;
                end
            end
        end
    end

    function automatic int ones(logic [31:0] x);
        int c;
        c = 0;
        for (int i = 0; i < 32; i++)
            c += x[i];
        return c;
    endfunction

    function automatic void load_scratch();
        logic [31:0] m;
        m = (live_count >= 32) ? 32'hFFFF_FFFF : ((32'd1 << live_count) - 1);
        for (int i = 0; i < 32; i++)
            scratch[i] = (i < live_count) ? (graph_rows[i] & m) : '0;
    endfunction

    function automatic void remove_vertex(int v);
        scratch[v] = '0;
        for (int i = 0; i < 32; i++)
            scratch[i][v] = 1'b0;
    endfunction

    function automatic bit any_edge();
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++)
            acc |= scratch[i];
        return acc != 0;
    endfunction

    function automatic void append_cover(cover_word_t w);
        pending_covers = {pending_covers, w};
    endfunction

    function automatic void push_set(logic [31:0] s, logic alg);
        cover_word_t w;
        for (int v = 0; v < 32; v++)
            if (s[v])
            begin
                w = '{alg: alg, vtx: v[4:0], empty: 1'b0, fin: 1'b0};
                append_cover(w);
            end
    endfunction

    // predict the covers for one accepted word
    function automatic void predict_covers(logic [1:0] k, logic [5:0] n,
                                           logic [4:0] a, logic [4:0] b);
        logic [31:0] greedy;
        logic [31:0] pairs;
        logic [31:0] row;
        int          best;
        int          col;
        cover_word_t w;
        greedy = '0;
        pairs = '0;
        if (k == KIND_NEW)
        begin
            for (int i = 0; i < 32; i++)
                graph_rows[i] = '0;
            live_count = (n > 32) ? 32 : n;
        end
        else if (k == KIND_EDGE)
        begin
            if (a < live_count && b < live_count && a != b)
            begin
                graph_rows[a][b] = 1'b1;
                graph_rows[b][a] = 1'b1;
            end
        end
        else if (k == KIND_SOLVE)
        begin
            solves_sent++;
            load_scratch();
            if (!any_edge())
            begin
                w = '{alg: 1'b0, vtx: 5'd0, empty: 1'b1, fin: 1'b1};
                append_cover(w);
                return;
            end
            while (any_edge())
            begin
                best = 0;
                for (int v = 0; v < live_count; v++)
                    if (ones(scratch[v]) > ones(scratch[best]))
                        best = v;
                greedy[best] = 1'b1;
                remove_vertex(best);
            end
            load_scratch();
            for (int r = 0; r < live_count; r++)
            begin
                row = scratch[r];
                if (row != 0)
                begin
                    col = 0;
                    while (!row[col])
                        col++;
                    pairs[r] = 1'b1;
                    pairs[col] = 1'b1;
                    remove_vertex(r);
                    remove_vertex(col);
                end
            end
            push_set(greedy, 1'b0);
            push_set(pairs, 1'b1);
            pending_covers[$].fin = 1'b1;
        end
    endfunction

    task automatic send_word(logic [1:0] k, logic [5:0] n, logic [4:0] a, logic [4:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        vertex_count <= n;
        vert_a <= a;
        vert_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_covers(k, n, a, b);
    endtask

    task automatic drain_covers();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_covers.size() != 0)
            @(posedge clk);
        // edge words cause no result but may still sit in the queue
        while (guard < 20)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic test_directed();
        send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
        send_word(KIND_NEW, 6'd0, 5'd0, 5'd0);
        send_word(KIND_EDGE, 6'd0, 5'd0, 5'd1);
        send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
        send_word(KIND_NEW, 6'd63, 5'd0, 5'd0);
        send_word(KIND_EDGE, 6'd0, 5'd0, 5'd31);
        send_word(KIND_EDGE, 6'd0, 5'd7, 5'd7);
        send_word(KIND_SPARE, 6'd63, 5'd31, 5'd31);
        send_word(KIND_EDGE, 6'd0, 5'd31, 5'd15);
        send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
        send_word(KIND_EDGE, 6'd0, 5'd1, 5'd2);
        send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
        send_word(KIND_NEW, 6'd4, 5'd0, 5'd0);
        send_word(KIND_EDGE, 6'd0, 5'd3, 5'd4);
        send_word(KIND_EDGE, 6'd0, 5'd5, 5'd1);
        send_word(KIND_EDGE, 6'd0, 5'd0, 5'd1);
        send_word(KIND_EDGE, 6'd0, 5'd1, 5'd2);
        send_word(KIND_EDGE, 6'd0, 5'd2, 5'd3);
        send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
        send_word(KIND_NEW, 6'd32, 5'd0, 5'd0);
        for (int i = 1; i < 32; i++)
            send_word(KIND_EDGE, 6'd0, 5'd0, i[4:0]);
        send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
        drain_covers();
    endtask

    // random graphs: new, a batch of edges with some random words mixed in, a solve, sometimes another edge and solve
    task automatic test_random_graphs(int words);
        int sent;
        int n;
        int edges;
        sent = 0;
        while (sent < words)
        begin
            n = ($urandom_range(9) == 0) ? int'($urandom_range(63))
                                         : int'($urandom_range(2, 12));
            send_word(KIND_NEW, n[5:0], 5'($urandom), 5'($urandom));
            edges = $urandom_range(0, 12);
            for (int e = 0; e < edges; e++)
            begin
                if ($urandom_range(9) == 0)
                    send_word(2'($urandom_range(3)), 6'($urandom), 5'($urandom),
                              5'($urandom));
                else
                    send_word(KIND_EDGE, 6'($urandom),
                              5'($urandom_range(n > 0 ? n - 1 : 0)),
                              5'($urandom_range(n > 0 ? n - 1 : 0)));
            end
            send_word(KIND_SOLVE, 6'($urandom), 5'($urandom), 5'($urandom));
            if ($urandom_range(3) == 0)
            begin
                send_word(KIND_EDGE, 6'($urandom),
                          5'($urandom_range(n > 0 ? n - 1 : 0)),
                          5'($urandom_range(n > 0 ? n - 1 : 0)));
                send_word(KIND_SOLVE, 6'($urandom), 5'($urandom), 5'($urandom));
                sent += 2;
            end
            sent += edges + 2;
        end
        drain_covers();
    endtask

    // hold the receiver off while solves pile up behind the input queue
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_word(KIND_NEW, 6'd6, 5'd0, 5'd0);
                for (int i = 0; i < 5; i++)
                    send_word(KIND_EDGE, 6'd0, i[4:0], 5'(i + 1));
                for (int i = 0; i < 8; i++)
                    send_word(KIND_SOLVE, 6'd0, 5'd0, 5'd0);
                in_valid <= 1'b0;
            end
        join
        drain_covers();
    endtask

    initial
    begin
        live_count = 0;
        for (int i = 0; i < 32; i++)
            graph_rows[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        send_idle_pct = 13;
        recv_idle_pct = 77;
        test_random_graphs(140);
        send_idle_pct = 77;
        recv_idle_pct = 13;
        test_random_graphs(140);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_graphs(140);
        $display("covered %0d solves, %0d cover words checked", solves_sent, words_seen);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
